>>> sv/ptc_pkg.sv
// Shared types, constants and helper functions for the pressure and
// temperature compensation pipeline. No dependencies.
`default_nettype none

package ptc_pkg;

  // One packed register of three 16-bit trim words.
  typedef logic [47:0] trim_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TEMP_TRIM  = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_MID  = 2'd2,
    REG_PRESS_HIGH = 2'd3
  } reg_idx_t;

  // Arithmetic constants of the compensation formulas.
  localparam logic [32:0] T_OFFSET = 33'd128000;
  localparam logic [31:0] T_ROUND  = 32'd128;
  localparam logic [20:0] P_FULL   = 21'd1048576;
  localparam logic [63:0] P_SCALE  = 64'd3125;
  localparam logic [63:0] K_BIAS   = 64'h0000_8000_0000_0000;

  // Stage counts of the sub-units.
  localparam int TEMP_LAT  = 6;
  localparam int MUL_LAT   = 2;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // Arithmetic right shift of a 64-bit pattern.
  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    logic signed [63:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  // Arithmetic right shift of a 32-bit pattern.
  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  // Sign extension of a 16-bit trim word to 64 bits.
  function automatic logic [63:0] sext16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

endpackage

`default_nettype wire

>>> sv/ptc_delay.sv
// Enabled delay line of fixed depth for payload that rides along the pipeline.
// Depends on nothing.
`default_nettype none

module ptc_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Shift one place whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

`default_nettype wire

>>> sv/ptc_mul64.sv
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product.
// Depends on nothing.
`default_nettype none

module ptc_mul64 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // Partial products; the high by high term falls outside 64 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[31:0] * b[31:0];
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
    end
  end

  // Recombine.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= ll + {lh + hl, 32'd0};
    end
  end

endmodule

`default_nettype wire

>>> sv/ptc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating
// toward zero. Depends on ptc_pkg.
`default_nettype none

module ptc_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic      [63:0] quo
);
  import ptc_pkg::*;

  logic [63:0] rem   [DIV_STEPS+1];
  logic [63:0] shq   [DIV_STEPS+1];
  logic [63:0] dv    [DIV_STEPS+1];
  logic        neg   [DIV_STEPS+1];

  // Take magnitudes and note the quotient sign.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      shq[0] <= num[63] ? (64'd0 - num) : num;
      dv[0]  <= den[63] ? (64'd0 - den) : den;
      neg[0] <= num[63] ^ den[63];
    end
  end

  // Restoring division steps.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    assign trial = {rem[i], shq[i][63]};
    assign diff  = trial - {1'b0, dv[i]};
    assign ge    = trial >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[63:0] : trial[63:0];
        shq[i+1] <= {shq[i][62:0], ge};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  // Apply the sign; the single overflow case wraps naturally.
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[DIV_STEPS] ? (64'd0 - shq[DIV_STEPS]) : shq[DIV_STEPS];
    end
  end

endmodule

`default_nettype wire

>>> sv/ptc_temp.sv
// Temperature compensation stages: fine temperature, centidegree result and
// the offset pressure term. Depends on ptc_pkg.
`default_nettype none

module ptc_temp (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [19:0]         raw_t,
  input  wire ptc_pkg::trim_t      trim,
  output logic      [19:0]         tc,
  output logic      [32:0]         tx
);
  import ptc_pkg::*;

  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;
  logic signed [17:0] a;
  logic signed [16:0] b;
  logic signed [33:0] m1_full;
  logic signed [33:0] bb_full;
  logic [31:0]        m1;
  logic [31:0]        bb;
  logic [31:0]        bb_sh;
  logic [31:0]        v1;
  logic [31:0]        v1_d;
  logic signed [19:0] bb12;
  logic signed [35:0] m2_full;
  logic [31:0]        m2;
  logic [31:0]        tf;
  logic [31:0]        tf5;

  assign t1 = trim[15:0];
  assign t2 = trim[31:16];
  assign t3 = trim[47:32];

  // Stage 1: offsets from the first trim word.
  always_ff @(posedge clk) begin
    if (en) begin
      a <= {1'b0, raw_t[19:3]} - {1'b0, t1, 1'b0};
      b <= {1'b0, raw_t[19:4]} - {1'b0, t1};
    end
  end

  // Stage 2: linear term and square.
  assign m1_full = a * t2;
  assign bb_full = b * b;

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= m1_full[31:0];
      bb <= bb_full[31:0];
    end
  end

  // Stage 3: scale both terms.
  assign bb_sh = asr32(bb, 12);

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= asr32(m1, 11);
      bb12 <= bb_sh[19:0];
    end
  end

  // Stage 4: quadratic term.
  assign m2_full = bb12 * t3;

  always_ff @(posedge clk) begin
    if (en) begin
      m2   <= m2_full[31:0];
      v1_d <= v1;
    end
  end

  // Stage 5: fine temperature.
  always_ff @(posedge clk) begin
    if (en) begin
      tf <= v1_d + asr32(m2, 14);
    end
  end

  // Stage 6: rounded centidegrees and the pressure offset.
  assign tf5 = {tf[29:0], 2'd0} + tf + T_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      tc <= tf5[27:8];
      tx <= {tf[31], tf} - T_OFFSET;
    end
  end

endmodule

`default_nettype wire

>>> sv/pressure_temperature_compensation_top.sv
// Throughput: one item per cycle while the output is not stalled; the depth is set
// by the one-bit-per-stage divider (66 stages) plus the temperature and multiplier
// stages around it.
// A stalled output freezes the whole pipeline; an empty input stage still loads.
// Reset (rst, synchronous) clears all valid bits and the four trim registers.
`default_nettype none

module pressure_temperature_compensation_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      temperature_centi,
  output logic [31:0]      pressure_pa,
  output logic             pressure_valid
);
  import ptc_pkg::*;

  // Stage numbers, counted from the input register.
  localparam int ST_X   = TEMP_LAT;
  localparam int ST_SQ  = ST_X + 1;
  localparam int ST_M1  = ST_SQ + MUL_LAT;
  localparam int ST_YK  = ST_M1 + 1;
  localparam int ST_M2  = ST_YK + MUL_LAT;
  localparam int ST_NUM = ST_M2 + 1;
  localparam int ST_M3  = ST_NUM + MUL_LAT;
  localparam int ST_DIV = ST_M3 + DIV_LAT;
  localparam int ST_M4  = ST_DIV + MUL_LAT;
  localparam int ST_M5  = ST_M4 + MUL_LAT;
  localparam int ST_SUM = ST_M5 + 1;
  localparam int ST_OUT = ST_SUM + 1;
  localparam int PIPE_DEPTH = ST_OUT + 1;

  trim_t temp_trim;
  trim_t press_trim_low;
  trim_t press_trim_mid;
  trim_t press_trim_high;

  logic                  en;
  logic                  load0;
  logic [PIPE_DEPTH-1:0] vld;
  logic [19:0]           raw_t_q;
  logic [19:0]           raw_p_q;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_mid  <= '0;
      press_trim_high <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP_TRIM:  temp_trim       <= cfg_data;
        REG_PRESS_LOW:  press_trim_low  <= cfg_data;
        REG_PRESS_MID:  press_trim_mid  <= cfg_data;
        REG_PRESS_HIGH: press_trim_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance and input stage load.
  assign en        = ~vld[PIPE_DEPTH-1] | out_ready;
  assign load0     = en | ~vld[0];
  assign in_ready  = load0;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load0) begin
        vld[0] <= in_valid;
      end
      if (en) begin
        vld[PIPE_DEPTH-1:1] <= vld[PIPE_DEPTH-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      raw_t_q <= raw_temperature;
      raw_p_q <= raw_pressure;
    end
  end

  // Pressure trim words.
  logic [63:0]        c1_64;
  logic signed [15:0] c2;
  logic signed [15:0] c5;
  logic [63:0]        c3_64;
  logic [63:0]        c4_64;
  logic [63:0]        c6_64;
  logic [63:0]        c7_64;
  logic [63:0]        c8_64;
  logic [63:0]        c9_64;

  assign c1_64 = {48'd0, press_trim_low[15:0]};
  assign c2    = press_trim_low[31:16];
  assign c3_64 = sext16(press_trim_low[47:32]);
  assign c4_64 = sext16(press_trim_mid[15:0]);
  assign c5    = press_trim_mid[31:16];
  assign c6_64 = sext16(press_trim_mid[47:32]);
  assign c7_64 = sext16(press_trim_high[15:0]);
  assign c8_64 = sext16(press_trim_high[31:16]);
  assign c9_64 = sext16(press_trim_high[47:32]);

  // Temperature stages.
  logic [19:0] tc;
  logic [32:0] tx;

  ptc_temp u_temp (
    .clk   (clk),
    .en    (en),
    .raw_t (raw_t_q),
    .trim  (temp_trim),
    .tc    (tc),
    .tx    (tx)
  );

  // Square and linear terms of the offset.
  logic signed [32:0] xs;
  logic signed [65:0] xx_full;
  logic signed [48:0] xc5_full;
  logic signed [48:0] xc2_full;
  logic [63:0]        xx;
  logic [48:0]        xc5;
  logic [48:0]        xc2;

  assign xs       = tx;
  assign xx_full  = xs * xs;
  assign xc5_full = xs * c5;
  assign xc2_full = xs * c2;

  always_ff @(posedge clk) begin
    if (en) begin
      xx  <= xx_full[63:0];
      xc5 <= xc5_full;
      xc2 <= xc2_full;
    end
  end

  logic [63:0] xx6;
  logic [63:0] xx3;
  logic [48:0] xc5_d;
  logic [48:0] xc2_d;

  ptc_mul64 u_mul_c6 (.clk(clk), .en(en), .a(xx), .b(c6_64), .p(xx6));
  ptc_mul64 u_mul_c3 (.clk(clk), .en(en), .a(xx), .b(c3_64), .p(xx3));

  ptc_delay #(.WIDTH(49), .DEPTH(MUL_LAT)) u_dly_xc5 (
    .clk(clk), .en(en), .din(xc5), .dout(xc5_d));
  ptc_delay #(.WIDTH(49), .DEPTH(MUL_LAT)) u_dly_xc2 (
    .clk(clk), .en(en), .din(xc2), .dout(xc2_d));

  // Sum the y polynomial and the divisor factor.
  logic [63:0] xc5_64;
  logic [63:0] xc2_64;
  logic [63:0] y;
  logic [63:0] k;

  assign xc5_64 = {{15{xc5_d[48]}}, xc5_d};
  assign xc2_64 = {{15{xc2_d[48]}}, xc2_d};

  always_ff @(posedge clk) begin
    if (en) begin
      y <= xx6 + {xc5_64[46:0], 17'd0} + {c4_64[28:0], 35'd0};
      k <= asr64(xx3, 8) + {xc2_64[51:0], 12'd0} + K_BIAS;
    end
  end

  logic [63:0] kc;
  logic [63:0] y_d;
  logic [19:0] raw_p_d;

  ptc_mul64 u_mul_c1 (.clk(clk), .en(en), .a(k), .b(c1_64), .p(kc));

  ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_y (
    .clk(clk), .en(en), .din(y), .dout(y_d));
  ptc_delay #(.WIDTH(20), .DEPTH(ST_M2)) u_dly_rawp (
    .clk(clk), .en(en), .din(raw_p_q), .dout(raw_p_d));

  // Divisor and dividend before scaling.
  logic [20:0] praw;
  logic [63:0] xd;
  logic [63:0] num0;

  assign praw = P_FULL - {1'b0, raw_p_d};

  always_ff @(posedge clk) begin
    if (en) begin
      xd   <= asr64(kc, 33);
      num0 <= {12'd0, praw, 31'd0} - y_d;
    end
  end

  logic [63:0] num;
  logic [63:0] xd_d;
  logic        zero;
  logic        zero_d;
  logic [19:0] tc_d;
  logic [63:0] pq;

  ptc_mul64 u_mul_scale (.clk(clk), .en(en), .a(num0), .b(P_SCALE), .p(num));

  ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_xd (
    .clk(clk), .en(en), .din(xd), .dout(xd_d));

  // Division; a zero divisor is flagged and masked at the end.
  assign zero = (xd_d == 64'd0);

  ptc_div u_div (.clk(clk), .en(en), .num(num), .den(xd_d), .quo(pq));

  ptc_delay #(.WIDTH(1), .DEPTH(ST_SUM - ST_M3)) u_dly_zero (
    .clk(clk), .en(en), .din(zero), .dout(zero_d));
  ptc_delay #(.WIDTH(20), .DEPTH(ST_SUM - ST_X)) u_dly_tc (
    .clk(clk), .en(en), .din(tc), .dout(tc_d));

  // Second-order pressure correction.
  logic [63:0] q;
  logic [63:0] q_d;
  logic [63:0] c9q;
  logic [63:0] xq;
  logic [63:0] c8p;
  logic [63:0] c8p_d;
  logic [63:0] pq_d;

  assign q = asr64(pq, 13);

  ptc_mul64 u_mul_c9 (.clk(clk), .en(en), .a(c9_64), .b(q), .p(c9q));
  ptc_mul64 u_mul_c8 (.clk(clk), .en(en), .a(c8_64), .b(pq), .p(c8p));
  ptc_mul64 u_mul_qq (.clk(clk), .en(en), .a(c9q), .b(q_d), .p(xq));

  ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_q (
    .clk(clk), .en(en), .din(q), .dout(q_d));
  ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_c8p (
    .clk(clk), .en(en), .din(c8p), .dout(c8p_d));
  ptc_delay #(.WIDTH(64), .DEPTH(2 * MUL_LAT)) u_dly_p (
    .clk(clk), .en(en), .din(pq), .dout(pq_d));

  logic [63:0] psum;
  logic [63:0] pfin;

  always_ff @(posedge clk) begin
    if (en) begin
      psum <= pq_d + asr64(xq, 25) + asr64(c8p_d, 19);
    end
  end

  // Output register.
  assign pfin = asr64(asr64(psum, 8) + {c7_64[59:0], 4'd0}, 8);

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_centi <= tc_d;
      pressure_pa       <= zero_d ? 32'd0 : pfin[31:0];
      pressure_valid    <= ~zero_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/ptc_checker.sv
// Port-level checks for the compensation pipeline and the bind that attaches
// them to the top level. Depends on pressure_temperature_compensation_top.
`default_nettype none

module ptc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [47:0] cfg_data,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [19:0] raw_temperature,
  input wire logic [19:0] raw_pressure,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [19:0] temperature_centi,
  input wire logic [31:0] pressure_pa,
  input wire logic        pressure_valid
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A free output side never blocks the input side.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side ready");

  // A flagged pressure is forced to zero.
  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pressure_valid) |-> (pressure_pa == 32'd0))
    else $error("invalid pressure not zero");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(pressure_pa) && $stable(temperature_centi)
      && $stable(pressure_valid)))
    else $error("result changed while stalled");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (.*);

`default_nettype wire

>>> tb/pressure_temperature_compensation_top_tb.sv
// Testbench for the pressure and temperature compensation pipeline.
// It predicts every result from the trim registers and the raw readings and compares it.
// Depends on ptc_pkg and pressure_temperature_compensation_top.
`timescale 1ns / 100ps

module pressure_temperature_compensation_top_tb;
  import ptc_pkg::*;

  // One predicted result of a compensation.
  typedef struct {
    logic [19:0] temp;
    logic [31:0] press;
    logic        pvalid;
  } comp_result_t;

  // Scoreboard that holds the trim registers and the queue of predicted results.
  class comp_scoreboard;
    logic [47:0] trim [4];
    comp_result_t pending [$];
    int mismatches;

    function new();
      foreach (trim[i]) trim[i] = '0;
      mismatches = 0;
    endfunction

    function automatic logic [63:0] trim_word(int r, int k);
      return {{48{trim[r][16*k+15]}}, trim[r][16*k +: 16]};
    endfunction

    // Predict the result of one accepted input transfer.
    function void note_input(logic [19:0] adc_t, logic [19:0] adc_p);
      logic signed [31:0] t1, t2, t3, a, v1, b, v2, tf, tc;
      logic signed [63:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
      logic signed [63:0] x, y, p, q, un, ud, uq;
      comp_result_t r;
      t1 = {16'd0, trim[0][15:0]};
      t2 = {{16{trim[0][31]}}, trim[0][31:16]};
      t3 = {{16{trim[0][47]}}, trim[0][47:32]};
      a = ({12'd0, adc_t} >> 3) - (t1 << 1);
      v1 = (a * t2) >>> 11;
      b = ({12'd0, adc_t} >> 4) - t1;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      tc = (tf * 5 + 128) >>> 8;
      r.temp = tc[19:0];
      c1 = {48'd0, trim[1][15:0]};
      c2 = trim_word(1, 1); c3 = trim_word(1, 2);
      c4 = trim_word(2, 0); c5 = trim_word(2, 1); c6 = trim_word(2, 2);
      c7 = trim_word(3, 0); c8 = trim_word(3, 1); c9 = trim_word(3, 2);
      x = 64'(tf) - 64'sd128000;
      y = x * x * c6;
      y = y + ((x * c5) <<< 17);
      y = y + (c4 <<< 35);
      x = ((x * x * c3) >>> 8) + ((x * c2) <<< 12);
      x = (((64'sd1 <<< 47) + x) * c1) >>> 33;
      if (x == 0) begin
        r.press = '0;
        r.pvalid = 1'b0;
      end else begin
        p = 64'sd1048576 - {44'd0, adc_p};
        p = ((p <<< 31) - y) * 64'sd3125;
        // Truncating division done on magnitudes so the overflow case wraps.
        un = p[63] ? -p : p;
        ud = x[63] ? -x : x;
        uq = $signed(64'($unsigned(un) / $unsigned(ud)));
        p = (p[63] != x[63]) ? -uq : uq;
        q = p >>> 13;
        x = (c9 * q * q) >>> 25;
        y = (c8 * p) >>> 19;
        p = ((p + x + y) >>> 8) + (c7 <<< 4);
        p = p >>> 8;
        r.press = p[31:0];
        r.pvalid = 1'b1;
      end
      pending.push_back(r);
    endfunction

    // Compare one result transfer against the oldest prediction.
    function void check_result(logic [19:0] temp, logic [31:0] press, logic pvalid);
      comp_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %h %h %b", temp, press, pvalid);
        return;
      end
      e = pending.pop_front();
      if (e.temp !== temp || e.press !== press || e.pvalid !== pvalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h %h %b, got %h %h %b",
                   e.temp, e.press, e.pvalid, temp, press, pvalid);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [19:0] temperature_centi;
  logic [31:0] pressure_pa;
  logic pressure_valid;
  bit calm = 1'b0;
  comp_scoreboard sb = new();

  pressure_temperature_compensation_top i_dut (.*);

  always #1 clk = ~clk;

  // Note input transfers and check result transfers at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(raw_temperature, raw_pressure);
    if (!rst && out_valid && out_ready)
      sb.check_result(temperature_centi, pressure_pa, pressure_valid);
  end

  // Receiver stalls at random except in calm stretches.
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 33);

  task automatic write_reg(reg_idx_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    sb.trim[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering, wait until every prediction has been matched, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Offer one item, with a random gap before it, and hold it until accepted.
  // The valid stays high after the transfer unless the next item idles first.
  task automatic send(logic [19:0] t, logic [19:0] p);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; raw_temperature <= t; raw_pressure <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Realistic factory trim set with some random jitter.
  task automatic typical_trim();
    write_reg(REG_TEMP_TRIM, {16'hFC18 ^ 16'($urandom_range(63)), 16'd26435, 16'd27504});
    write_reg(REG_PRESS_LOW, {16'd8192 - 16'($urandom_range(200)), 16'hD67A, 16'd36477});
    write_reg(REG_PRESS_MID, {16'hFFF9, 16'hFF8C, 16'd2855 + 16'($urandom_range(99))});
    write_reg(REG_PRESS_HIGH, {16'd6000, 16'hC6F8, 16'd15500});
  endtask

  task automatic random_items(int n);
    repeat (n) send(20'($urandom), 20'($urandom));
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    // Reset trims: divisor is zero, so pressure is flagged invalid.
    send('0, '0);
    send(20'hFFFFF, 20'hFFFFF);
    drain();
    typical_trim();
    send(20'd519888, 20'd415148);
    send('0, '0);
    send(20'hFFFFF, 20'hFFFFF);
    send('0, 20'hFFFFF);
    send(20'hFFFFF, '0);
    send(20'h55555, 20'hAAAAA);
    drain();
    // Extreme trims: all ones, then most negative words.
    foreach (sb.trim[i]) write_reg(reg_idx_t'(i), 48'hFFFF_FFFF_FFFF);
    send('0, '0); send(20'hFFFFF, 20'hFFFFF); send(20'h80000, 20'h7FFFF);
    drain();
    foreach (sb.trim[i]) write_reg(reg_idx_t'(i), 48'h8000_8000_8000);
    send('0, '0); send(20'hFFFFF, 20'hFFFFF); send(20'h12345, 20'h54321);
    drain();
    // Typical trims with random readings; one stretch without idling.
    typical_trim();
    random_items(250);
    calm = 1'b1;
    random_items(100);
    calm = 1'b0;
    drain();
    // Fully random trims.
    foreach (sb.trim[i]) write_reg(reg_idx_t'(i), {16'($urandom), 32'($urandom)});
    random_items(180);
    drain();
    typical_trim();
    random_items(200);
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("pressure_temperature_compensation_top verification clean");
    else
      $display("pressure_temperature_compensation_top verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("pressure_temperature_compensation_top verification failed");
    $finish;
  end
endmodule

>>> pressure_temperature_compensation_top.f
sv/ptc_pkg.sv
sv/ptc_delay.sv
sv/ptc_mul64.sv
sv/ptc_div.sv
sv/ptc_temp.sv
sv/pressure_temperature_compensation_top.sv
sv/ptc_checker.sv
tb/pressure_temperature_compensation_top_tb.sv
